@@ sv/plt_pkg.sv @@
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the positional list table
// Command codes and field widths of the stream beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 7;
    localparam int ELEM_W    = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/plt_ram.sv @@
// ----------------------------------------------------------------------------
// plt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plt_ram #(
    parameter int WIDTH = plt_pkg::ELEM_W,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/positional_list_table_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_table_unit: ordered list of bytes with positional commands
// Insert, delete, get, locate and clear on a list held in a RAM; entries are
// moved one per cycle by a small sequencer around the RAM ports.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on s_tvalid/s_tready/s_tdata; s_tready is high only
//   while the sequencer is idle. Each command gives exactly one result beat
//   on m_tvalid/m_tready/m_tdata.
//   Clear, unknown commands, rejected positions and locate on an empty list
//   go straight to the output state; append writes the RAM first and get
//   reads it first. Insert, delete and locate walk the RAM one entry per
//   cycle through its single read port: insert at position p (not appending)
//   and delete walk entries p to count, locate walks from the front up to
//   the first match or the end of the list.
//   A new command is taken right after the result is loaded into the output
//   register, even while that result still waits for m_tready.
//   Reset empties the list (count 0); RAM contents are not cleared and need
//   no clearing pass. A stalled receiver holds the result beat steady and
//   the sequencer waits in its output state until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_table_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd[2:0], pos[9:3], elem_in[17:10], zero pad [23:18]
    input  wire logic [plt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], elem_out[8:1], found_pos[15:9], count_out[22:16], is_empty[23]
    output logic      [plt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > plt_pkg::POS_W) ? CW : plt_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FILL,
        S_OUT
    } state_t;

    state_t                          state_reg, state_next;
    plt_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [plt_pkg::ELEM_W-1:0]      elem_reg, elem_next;
    logic [AW-1:0]                   pidx_reg, pidx_next;
    logic [AW-1:0]                   rd_addr_reg, rd_addr_next;
    logic                            p_valid_reg, p_valid_next;
    logic [AW-1:0]                   p_addr_reg, p_addr_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            ok_reg, ok_next;
    logic [plt_pkg::ELEM_W-1:0]      eout_reg, eout_next;
    logic [CW-1:0]                   found_reg, found_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [plt_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    plt_pkg::cmd_t                   in_cmd;
    logic [WW-1:0]                   pos_w, pos_m1, cnt_w, cnt_m1, fnd_w;
    logic                            ins_ok, rd_ok, hit, cap, last;
    logic                            ram_we, ram_re;
    logic [AW-1:0]                   ram_waddr;
    logic [plt_pkg::ELEM_W-1:0]      ram_wdata, ram_rdata;

    plt_ram #(
        .WIDTH (plt_pkg::ELEM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign in_cmd = plt_pkg::cmd_t'(s_tdata[2:0]);
    assign pos_w  = WW'(s_tdata[9:3]);
    assign pos_m1 = pos_w - WW'(1);
    assign cnt_w  = WW'(count_reg);
    assign cnt_m1 = cnt_w - WW'(1);
    assign fnd_w  = WW'(found_reg);
    assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + WW'(1)) && (cnt_w < WW'(CAPACITY));
    assign rd_ok  = (pos_w != '0) && (pos_w <= cnt_w);

    // result of the read issued last cycle
    assign hit = p_valid_reg && (cmd_reg == plt_pkg::CMD_LOCATE) && (ram_rdata == elem_reg);
    assign cap = p_valid_reg && (p_addr_reg == pidx_reg) &&
                 ((cmd_reg == plt_pkg::CMD_DELETE) || (cmd_reg == plt_pkg::CMD_GET));

    assign last = (cmd_reg == plt_pkg::CMD_GET) ||
                  ((cmd_reg == plt_pkg::CMD_INSERT) ? (rd_addr_reg == pidx_reg)
                                                    : (rd_addr_reg == cnt_m1[AW-1:0]));

    assign ram_we = (state_reg == S_FILL) ||
                    (p_valid_reg && ((cmd_reg == plt_pkg::CMD_INSERT) ||
                                     ((cmd_reg == plt_pkg::CMD_DELETE) &&
                                      (p_addr_reg != pidx_reg))));
    assign ram_waddr = (state_reg == S_FILL) ? pidx_reg :
                       (cmd_reg == plt_pkg::CMD_INSERT) ? (p_addr_reg + AW'(1))
                                                        : (p_addr_reg - AW'(1));
    assign ram_wdata = (state_reg == S_FILL) ? elem_reg : ram_rdata;
    assign ram_re    = (state_reg == S_WALK);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        elem_next     = elem_reg;
        pidx_next     = pidx_reg;
        rd_addr_next  = rd_addr_reg;
        p_valid_next  = 1'b0;
        p_addr_next   = p_addr_reg;
        count_next    = count_reg;
        ok_next       = ok_reg;
        eout_next     = eout_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cap)
        begin
            eout_next = ram_rdata;
        end
        if (hit)
        begin
            found_next = CW'(p_addr_reg) + CW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = in_cmd;
                    elem_next  = s_tdata[17:10];
                    pidx_next  = pos_m1[AW-1:0];
                    ok_next    = 1'b0;
                    eout_next  = '0;
                    found_next = '0;
                    state_next = S_OUT;
                    case (in_cmd)
                        plt_pkg::CMD_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                ok_next = 1'b1;
                                if (cnt_w >= pos_w)
                                begin
                                    rd_addr_next = cnt_m1[AW-1:0];
                                    state_next   = S_WALK;
                                end
                                else
                                begin
                                    state_next = S_FILL;
                                end
                            end
                        end
                        plt_pkg::CMD_DELETE, plt_pkg::CMD_GET:
                        begin
                            if (rd_ok)
                            begin
                                ok_next      = 1'b1;
                                rd_addr_next = pos_m1[AW-1:0];
                                state_next   = S_WALK;
                            end
                        end
                        plt_pkg::CMD_LOCATE:
                        begin
                            ok_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                rd_addr_next = '0;
                                state_next   = S_WALK;
                            end
                        end
                        plt_pkg::CMD_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                p_valid_next = 1'b1;
                p_addr_next  = rd_addr_reg;
                if (hit)
                begin
                    p_valid_next = 1'b0;
                    state_next   = S_OUT;
                end
                else if (last)
                begin
                    state_next = S_DRAIN;
                end
                else if (cmd_reg == plt_pkg::CMD_INSERT)
                begin
                    rd_addr_next = rd_addr_reg - AW'(1);
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (cmd_reg == plt_pkg::CMD_INSERT)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    if (cmd_reg == plt_pkg::CMD_DELETE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_OUT;
                end
            end
            S_FILL:
            begin
                count_next = count_reg + CW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(count_reg == '0), cnt_w[6:0], fnd_w[6:0],
                                     eout_reg, ok_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= plt_pkg::CMD_CLEAR;
            elem_reg     <= '0;
            pidx_reg     <= '0;
            rd_addr_reg  <= '0;
            p_valid_reg  <= 1'b0;
            p_addr_reg   <= '0;
            count_reg    <= '0;
            ok_reg       <= 1'b0;
            eout_reg     <= '0;
            found_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            elem_reg     <= elem_next;
            pidx_reg     <= pidx_next;
            rd_addr_reg  <= rd_addr_next;
            p_valid_reg  <= p_valid_next;
            p_addr_reg   <= p_addr_next;
            count_reg    <= count_next;
            ok_reg       <= ok_next;
            eout_reg     <= eout_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_w <= WW'(CAPACITY))
        else $error("list count beyond capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_WALK || state_reg == S_DRAIN || state_reg == S_FILL))
        else $error("RAM write outside a command");

    a_pending_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> $past(state_reg == S_WALK))
        else $error("pending read without a walk cycle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted beat left sequencer idle");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for positional_list_table_unit
// Command beats are queued up front and driven with random source gaps. Each
// accepted command is applied to a shadow list. The result it gives is queued
// and compared field by field with the result beats, under random sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY      = 64;
    localparam int RANDOM_ITEMS  = 580;
    localparam int CALM_TAIL     = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;
    localparam int CMD_W         = plt_pkg::CMD_W;
    localparam int POS_W         = plt_pkg::POS_W;
    localparam int ELEM_W        = plt_pkg::ELEM_W;
    localparam int S_TDATA_W     = plt_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = plt_pkg::M_TDATA_W;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [POS_W-1:0]  pos;
        logic [CMD_W-1:0]  cmd;
    } cmd_beat_t;

    typedef struct packed {
        logic              is_empty;
        logic [POS_W-1:0]  count_out;
        logic [POS_W-1:0]  found_pos;
        logic [ELEM_W-1:0] elem_out;
        logic              ok;
    } result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 calm     = 1'b0;

    cmd_beat_t   cmd_backlog[$];
    result_t     list_results[$];
    logic [7:0]  list_mem [CAPACITY];
    int          list_len     = 0;
    int          gen_len      = 0;
    int          mismatches   = 0;
    int          src_gap      = 0;
    int          sink_stall   = 0;
    int          quiet_cycles = 0;
    result_t     got;
    result_t     want;

    positional_list_table_unit #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cmd, pos, elem_in, zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // ok, elem_out, found_pos, count_out, is_empty
    );

    always #5 clk = ~clk;

    // shadow list: applies one command and returns the result it must give
    function automatic result_t list_apply(cmd_beat_t c);
        result_t r;
        int      p;
        int      j;
        r = '0;
        p = int'(c.pos);
        case (c.cmd)
            plt_pkg::CMD_INSERT:
                if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY)
                begin
                    for (j = list_len; j >= p; j--)
                        list_mem[j] = list_mem[j - 1];
                    list_mem[p - 1] = c.elem;
                    list_len++;
                    r.ok = 1'b1;
                end
            plt_pkg::CMD_DELETE:
                if (p >= 1 && p <= list_len)
                begin
                    r.elem_out = list_mem[p - 1];
                    for (j = p - 1; j + 1 < list_len; j++)
                        list_mem[j] = list_mem[j + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            plt_pkg::CMD_GET:
                if (p >= 1 && p <= list_len)
                begin
                    r.elem_out = list_mem[p - 1];
                    r.ok = 1'b1;
                end
            plt_pkg::CMD_LOCATE:
            begin
                for (j = 0; j < list_len; j++)
                begin
                    if (list_mem[j] == c.elem)
                    begin
                        r.found_pos = POS_W'(j + 1);
                        break;
                    end
                end
                r.ok = 1'b1;
            end
            plt_pkg::CMD_CLEAR:
            begin
                list_len = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count_out = POS_W'(list_len);
        r.is_empty  = (list_len == 0);
        return r;
    endfunction

    // gen_len follows the list length so that generated positions stay useful
    task automatic queue_cmd(int op, int p, int e);
        cmd_beat_t b;
        b.cmd  = CMD_W'(op);
        b.pos  = POS_W'(p);
        b.elem = ELEM_W'(e);
        cmd_backlog.push_back(b);
        if (op == plt_pkg::CMD_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < CAPACITY)
            gen_len++;
        else if (op == plt_pkg::CMD_DELETE && p >= 1 && p <= gen_len)
            gen_len--;
        else if (op == plt_pkg::CMD_CLEAR)
            gen_len = 0;
    endtask

    // half of the values come from a narrow pool so that locate often hits
    function automatic int pick_elem();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 7);
        return $urandom_range(0, 255);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            calm     <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                list_results.push_back(list_apply(cmd_beat_t'(s_tdata[17:0])));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 4) == 0)
                begin
                    src_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, cmd_backlog.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
            calm <= (cmd_backlog.size() < CALM_TAIL);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (list_results.size() == 0)
                begin
                    $error("result beat with no command pending: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = list_results.pop_front();
                    if (got.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                        mismatches++;
                    end
                    if (got.elem_out !== want.elem_out)
                    begin
                        $error("elem_out: expected %0d, actual %0d",
                               want.elem_out, got.elem_out);
                        mismatches++;
                    end
                    if (got.found_pos !== want.found_pos)
                    begin
                        $error("found_pos: expected %0d, actual %0d",
                               want.found_pos, got.found_pos);
                        mismatches++;
                    end
                    if (got.count_out !== want.count_out)
                    begin
                        $error("count_out: expected %0d, actual %0d",
                               want.count_out, got.count_out);
                        mismatches++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, got.is_empty);
                        mismatches++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall = sink_stall - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                sink_stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("positional_list_table_unit test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int n_random;
        int phase;
        int burst;
        int k;
        int pick;

        // empty list, bad positions, front / middle / back edits, bad opcodes
        queue_cmd(plt_pkg::CMD_GET,    1,   0);
        queue_cmd(plt_pkg::CMD_DELETE, 1,   0);
        queue_cmd(plt_pkg::CMD_LOCATE, 0,   0);
        queue_cmd(plt_pkg::CMD_INSERT, 0,   1);
        queue_cmd(plt_pkg::CMD_INSERT, 2,   1);
        queue_cmd(plt_pkg::CMD_INSERT, 1,   8'h00);
        queue_cmd(plt_pkg::CMD_INSERT, 2,   8'hFF);
        queue_cmd(plt_pkg::CMD_INSERT, 1,   8'hAA);
        queue_cmd(plt_pkg::CMD_INSERT, 3,   8'h55);
        queue_cmd(plt_pkg::CMD_INSERT, 6,   8'h12);
        queue_cmd(plt_pkg::CMD_GET,    1,   0);
        queue_cmd(plt_pkg::CMD_GET,    4,   0);
        queue_cmd(plt_pkg::CMD_GET,    5,   0);
        queue_cmd(plt_pkg::CMD_GET,    0,   0);
        queue_cmd(plt_pkg::CMD_LOCATE, 0,   8'hFF);
        queue_cmd(plt_pkg::CMD_LOCATE, 0,   8'h12);
        queue_cmd(plt_pkg::CMD_LOCATE, 127, 8'hAA);
        queue_cmd(plt_pkg::CMD_DELETE, 4,   0);
        queue_cmd(plt_pkg::CMD_DELETE, 1,   0);
        queue_cmd(5,                   127, 8'hFF);
        queue_cmd(6,                   1,   8'h01);
        queue_cmd(7,                   64,  8'h00);
        queue_cmd(plt_pkg::CMD_CLEAR,  0,   0);
        queue_cmd(plt_pkg::CMD_LOCATE, 0,   8'h00);
        queue_cmd(plt_pkg::CMD_DELETE, 64,  0);

        // episodes: growth up to full, shrink, mixed traffic, noise
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            phase = $urandom_range(0, 9);
            burst = (phase == 9) ? $urandom_range(1, 6) : $urandom_range(8, 75);
            if (burst > RANDOM_ITEMS - n_random)
                burst = RANDOM_ITEMS - n_random;
            for (k = 0; k < burst; k++)
            begin
                pick = $urandom_range(0, 99);
                if (phase <= 3)
                begin
                    if (pick < 82)
                        queue_cmd(plt_pkg::CMD_INSERT, $urandom_range(1, gen_len + 1),
                                  pick_elem());
                    else if (pick < 91)
                        queue_cmd(plt_pkg::CMD_GET, $urandom_range(1, gen_len), 0);
                    else
                        queue_cmd(plt_pkg::CMD_LOCATE, 0, pick_elem());
                end
                else if (phase <= 6)
                begin
                    if (pick < 65)
                        queue_cmd(plt_pkg::CMD_DELETE, $urandom_range(1, gen_len), 0);
                    else if (pick < 80)
                        queue_cmd(plt_pkg::CMD_GET, $urandom_range(1, gen_len), 0);
                    else if (pick < 92)
                        queue_cmd(plt_pkg::CMD_LOCATE, $urandom_range(0, 127), pick_elem());
                    else
                        queue_cmd(plt_pkg::CMD_INSERT, $urandom_range(1, gen_len + 1),
                                  pick_elem());
                end
                else if (phase <= 8)
                    queue_cmd($urandom_range(0, 3), $urandom_range(0, gen_len + 2),
                              pick_elem());
                else
                begin
                    if (pick < 30)
                        queue_cmd(plt_pkg::CMD_CLEAR, $urandom_range(0, 127),
                                  $urandom_range(0, 255));
                    else
                        queue_cmd($urandom_range(0, 7), $urandom_range(0, 127),
                                  $urandom_range(0, 255));
                end
            end
            n_random += burst;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || s_tvalid || list_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("positional_list_table_unit test passed");
        else
            $display("positional_list_table_unit test failed");
        $finish;
    end

endmodule
